// ----- rtl/fsd_pkg.sv -----
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared constants, types and fixed-point helpers of the 1bpp dither packer.
// ----------------------------------------------------------------------------
`default_nettype none

package fsd_pkg;

  // field and register widths
  localparam int PixW      = 8;
  localparam int ErrW      = 18;   // signed error, 8 fraction bits
  localparam int SumW      = 21;   // pixel plus two errors, signed
  localparam int CfgDataW  = 16;
  localparam int CfgIdxW   = 1;
  localparam int CfgWidthW = 11;
  localparam int CfgHeightW = 16;

  localparam int DefaultMaxWidth = 1024;

  // fixed-point levels
  localparam int ErrLimit   = 511 * 256;
  localparam int Threshold  = 128 * 256;
  localparam int WhiteLevel = 255 * 256;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'b1;

  localparam logic [CfgWidthW-1:0]  WidthReset  = 11'd1024;
  localparam logic [CfgHeightW-1:0] HeightReset = 16'd1;

  // position of the pixel in the page
  typedef struct packed {
    logic row_end;
    logic last_row;
  } pix_ctl_t;

  // error unit results (two's complement vectors)
  typedef struct packed {
    logic            white;
    logic [ErrW-1:0] right_next;    // error for the next pixel of the row
    logic [ErrW-1:0] bl_write;      // final error of the entry left of this column
    logic [ErrW-1:0] bl_next;       // running error of this column's entry
    logic [ErrW-1:0] below_next;    // first share of the entry right of this column
  } err_res_t;

  function automatic logic signed [ErrW-1:0] clamp_err(input logic signed [SumW-1:0] v);
    logic signed [ErrW-1:0] r;
    if (v > ErrLimit) begin
      r = ErrW'(ErrLimit);
    end else if (v < -ErrLimit) begin
      r = ErrW'(-ErrLimit);
    end else begin
      r = ErrW'(v);
    end
    return r;
  endfunction

  // err * k / 16, truncated toward zero; k is at most 7, so no clamp is needed
  function automatic logic signed [ErrW-1:0] share(input logic signed [ErrW-1:0] err,
                                                   input logic [3:0] k);
    logic signed [ErrW+3:0] prod;
    logic signed [ErrW+3:0] biased;
    prod   = (ErrW+4)'(err) * $signed({{ErrW{1'b0}}, k});
    biased = prod[ErrW+3] ? prod + (ErrW+4)'(15) : prod;
    return ErrW'(biased >>> 4);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fsd_ram.sv -----
// ----------------------------------------------------------------------------
// fsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_ram #(
  parameter int Width = 18,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fsd_err_unit.sv -----
// ----------------------------------------------------------------------------
// fsd_err_unit
// Threshold of one pixel and Floyd-Steinberg split of its error.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_err_unit (
  input  wire logic [fsd_pkg::PixW-1:0] pixel_i,
  input  wire logic [fsd_pkg::ErrW-1:0] store_i,
  input  wire logic [fsd_pkg::ErrW-1:0] right_i,
  input  wire logic [fsd_pkg::ErrW-1:0] below_left_i,
  input  wire logic [fsd_pkg::ErrW-1:0] below_i,
  input  wire fsd_pkg::pix_ctl_t        ctl_i,
  output      fsd_pkg::err_res_t        res_o
);
  import fsd_pkg::*;

  logic signed [SumW-1:0] pix_ext;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] diff;
  logic signed [ErrW-1:0] err;
  logic signed [ErrW-1:0] b3;
  logic signed [ErrW-1:0] b5;
  logic signed [ErrW-1:0] b1;
  logic signed [ErrW-1:0] s7;
  logic                   white;

  always_comb begin
    pix_ext = $signed({{(SumW-PixW-8){1'b0}}, pixel_i, 8'h00});
    sum     = pix_ext + SumW'($signed(store_i)) + SumW'($signed(right_i));
    white   = (sum >= Threshold);
    diff    = white ? sum - SumW'(WhiteLevel) : sum;
    err     = clamp_err(diff);

    s7 = share(err, 4'd7);
    // no spill below the last row, nor past the row end
    b3 = ctl_i.last_row ? '0 : share(err, 4'd3);
    b5 = ctl_i.last_row ? '0 : share(err, 4'd5);
    b1 = (ctl_i.last_row || ctl_i.row_end) ? '0 : share(err, 4'd1);

    res_o.white      = white;
    res_o.right_next = ctl_i.row_end ? '0 : s7;
    res_o.bl_write   = clamp_err(SumW'($signed(below_left_i)) + SumW'(b3));
    res_o.bl_next    = clamp_err(SumW'($signed(below_i)) + SumW'(b5));
    res_o.below_next = b1;
  end

endmodule

`default_nettype wire

// ----- rtl/floyd_steinberg_1bpp_packer_core.sv -----
// ----------------------------------------------------------------------------
// floyd_steinberg_1bpp_packer_core
// Floyd-Steinberg dither of 8-bit gray pixels to 1bpp, packed MSB first.
// ----------------------------------------------------------------------------
//
//   port group | direction | request moves
//   -----------+-----------+------------------------------------------
//   cfg_*      | in        | register write (width, height), no wait
//   in_*       | in        | one gray pixel, raster order
//   out_*      | out       | packed byte with row and page last flags
//
// One pixel per clock sustained. A pixel is read from the line error RAM in
// the cycle it is taken and finished in the next, unless the finishing stage
// is held; its byte is in the output register in the cycle after it finishes.
// The error loop closes inside the finishing stage. After reset a clearing
// pass zeroes the line error RAM, with in_stall_o high. A stalled output holds
// a finishing pixel that ends a byte and so stalls the input in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module floyd_steinberg_1bpp_packer_core #(
  parameter int MAX_WIDTH = fsd_pkg::DefaultMaxWidth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [fsd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [fsd_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [fsd_pkg::PixW-1:0]       gray_pixel_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [7:0]                     packed_byte_o,
  output      logic                           row_last_o,
  output      logic                           page_last_o
);
  import fsd_pkg::*;

  localparam int CntW = $clog2(MAX_WIDTH);
  localparam int WCW  = (CntW + 1 > CfgWidthW) ? CntW + 1 : CfgWidthW;

  // configuration
  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [WCW-1:0]        w_ext;
  logic [WCW-1:0]        w_eff;
  logic [CfgHeightW:0]   h_eff;

  // clearing pass
  logic            clr_active_q;
  logic [CntW-1:0] clr_cnt_q;

  // position counters, owned by the accept side
  logic [CntW-1:0]       col_q;
  logic [CfgHeightW-1:0] row_q;
  pix_ctl_t              acc_ctl;
  logic                  accept;

  // finishing stage
  logic            s1_valid_q;
  logic [PixW-1:0] s1_pix_q;
  logic [CntW-1:0] s1_col_q;
  pix_ctl_t        s1_ctl_q;
  logic            emit;
  logic            s1_fire;

  // error state
  logic [ErrW-1:0] right_q;
  logic [ErrW-1:0] pbl_q;
  logic [ErrW-1:0] pb_q;
  logic [7:0]      acc_q;
  logic [7:0]      acc_new;
  err_res_t        err_res;

  // line error RAM and its bypass
  logic            mem_we;
  logic [CntW-1:0] mem_waddr;
  logic [ErrW-1:0] mem_wdata;
  logic [ErrW-1:0] ram_rdata;
  logic [ErrW-1:0] store_val;
  logic            direct_we;
  logic            hold_set;
  logic            hold_valid_q;
  logic [CntW-1:0] hold_addr_q;
  logic [ErrW-1:0] hold_data_q;
  logic            ov_valid_q;
  logic            ov_valid_d;
  logic [ErrW-1:0] ov_data_q;
  logic [ErrW-1:0] ov_data_d;
  logic [CntW-1:0] ov_target;

  // output register
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_row_q;
  logic            out_page_q;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegImageWidth:  width_q  <= cfg_wdata_i[CfgWidthW-1:0];
        RegImageHeight: height_q <= cfg_wdata_i[CfgHeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_ext = WCW'(width_q);
    if (w_ext == '0) begin
      w_eff = WCW'(1);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (height_q == '0) ? (CfgHeightW+1)'(1) : {1'b0, height_q};
  end

  // ---------------- clearing pass ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + CntW'(1);
      if (clr_cnt_q == CntW'(MAX_WIDTH - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // ---------------- handshake ----------------
  assign emit       = (s1_col_q[2:0] == 3'd7) || s1_ctl_q.row_end;
  assign s1_fire    = s1_valid_q && (!emit || !out_valid_q || !out_stall_i);
  assign in_stall_o = clr_active_q || (s1_valid_q && !s1_fire);
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------- accept side ----------------
  always_comb begin
    acc_ctl.row_end  = (WCW'(col_q) + WCW'(1)) >= w_eff;
    acc_ctl.last_row = ({1'b0, row_q} + (CfgHeightW+1)'(1)) >= h_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (acc_ctl.row_end) begin
        col_q <= '0;
        row_q <= acc_ctl.last_row ? '0 : row_q + CfgHeightW'(1);
      end else begin
        col_q <= col_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept || (s1_valid_q && !s1_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= gray_pixel_i;
      s1_col_q <= col_q;
      s1_ctl_q <= acc_ctl;
    end
  end

  // ---------------- line error RAM ----------------
  // the row-end write of the last column is held and written while no direct
  // write is due: the next pixel is column zero and has no write of its own
  assign direct_we = s1_fire && (s1_col_q != '0);
  assign hold_set  = s1_fire && s1_ctl_q.row_end;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hold_addr_q;
    mem_wdata = hold_data_q;
    if (clr_active_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (direct_we) begin
      mem_we    = 1'b1;
      mem_waddr = s1_col_q - CntW'(1);
      mem_wdata = err_res.bl_write;
    end else if (hold_valid_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (hold_set) begin
      hold_valid_q <= 1'b1;
    end else if (!direct_we) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_set) begin
      hold_addr_q <= s1_col_q;
      hold_data_q <= err_res.bl_next;
    end
  end

  fsd_ram #(
    .Width (ErrW),
    .Depth (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // bypass: catch writes to the waiting entry after its read was issued,
  // newest last
  always_comb begin
    ov_target  = accept ? col_q : s1_col_q;
    ov_valid_d = accept ? 1'b0 : ov_valid_q;
    ov_data_d  = ov_data_q;
    if (mem_we && (mem_waddr == ov_target)) begin
      ov_valid_d = 1'b1;
      ov_data_d  = mem_wdata;
    end
    if (hold_set && (s1_col_q == ov_target)) begin
      ov_valid_d = 1'b1;
      ov_data_d  = err_res.bl_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_valid_q <= 1'b0;
    end else begin
      ov_valid_q <= ov_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ov_data_q <= ov_data_d;
  end

  assign store_val = ov_valid_q ? ov_data_q : ram_rdata;

  // ---------------- error datapath ----------------
  fsd_err_unit u_err (
    .pixel_i      (s1_pix_q),
    .store_i      (store_val),
    .right_i      (right_q),
    .below_left_i (pbl_q),
    .below_i      (pb_q),
    .ctl_i        (s1_ctl_q),
    .res_o        (err_res)
  );

  assign acc_new = acc_q | (err_res.white ? (8'h80 >> s1_col_q[2:0]) : 8'h00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= '0;
      pbl_q   <= '0;
      pb_q    <= '0;
      acc_q   <= '0;
    end else if (s1_fire) begin
      right_q <= err_res.right_next;
      pbl_q   <= s1_ctl_q.row_end ? '0 : err_res.bl_next;
      pb_q    <= err_res.below_next;
      acc_q   <= emit ? 8'h00 : acc_new;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_byte_q <= acc_new;
      out_row_q  <= s1_ctl_q.row_end;
      out_page_q <= s1_ctl_q.row_end && s1_ctl_q.last_row;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = out_byte_q;
  assign row_last_o    = out_row_q;
  assign page_last_o   = out_page_q;

  // ---------------- assertions ----------------
  a_hold_no_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> !direct_we)
    else $error("held row-end write collides with a direct write");

  a_hold_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && !hold_set) |=> !hold_valid_q)
    else $error("held row-end write not drained");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> (!s1_valid_q && !hold_valid_q && !out_valid_q))
    else $error("activity during clearing pass");

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && emit) |=> out_valid_q)
    else $error("emitted byte missing from output register");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_col_q <= CntW'(MAX_WIDTH - 1)))
    else $error("column beyond line RAM depth");

endmodule

`default_nettype wire

// ----- tb/sv/floyd_steinberg_1bpp_packer_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// floyd_steinberg_1bpp_packer_core_tb
// Streams gray pixel pages through the dither packer with random flow control
// on both sides; checks each byte against a dither model or a directed value.
// ----------------------------------------------------------------------------
module floyd_steinberg_1bpp_packer_core_tb;
  import fsd_pkg::*;

  localparam int MaxWidth      = DefaultMaxWidth;
  localparam int IdlePct       = 26;
  localparam int LongRow       = 160;
  localparam int HoldAt        = 80;
  localparam int HoldCycles    = 300;
  localparam int QuietFrom     = 300;
  localparam int QuietLen      = 150;
  localparam int DrainCycles   = 8;
  localparam int WatchdogLimit = 5000;
  localparam int RandomPixels  = 380;

  typedef logic signed [ErrW-1:0] err_t;

  typedef struct packed {
    logic [7:0] pixels;
    logic       row_end;
    logic       page_end;
  } dot_byte_t;

  typedef struct packed {
    logic                is_write;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] value;
    logic                typed;
    dot_byte_t           want;
  } step_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = RegImageWidth;
  logic [CfgDataW-1:0] cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [PixW-1:0]     gray        = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [7:0]          packed_byte;
  logic                row_last;
  logic                page_last;

  // dither model state
  logic [CfgWidthW-1:0]  cfg_width;
  logic [CfgHeightW-1:0] cfg_height;
  err_t                  line_err [MaxWidth];
  err_t                  right_err;
  err_t                  pend_bl;
  err_t                  pend_below;
  int unsigned           col_cnt;
  int unsigned           row_cnt;
  logic [7:0]            bits_acc;

  dot_byte_t   expected_bytes [$];
  int unsigned pix_sent    = 0;
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;

  floyd_steinberg_1bpp_packer_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .gray_pixel_i (gray),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .packed_byte_o(packed_byte),
    .row_last_o   (row_last),
    .page_last_o  (page_last)
  );

  always #4 clk_i = ~clk_i;

  function automatic err_t sat_err(input longint v);
    if (v > ErrLimit) return err_t'(ErrLimit);
    if (v < -ErrLimit) return err_t'(-ErrLimit);
    return err_t'(v);
  endfunction

  function automatic err_t err_share(input err_t e, input int k);
    return sat_err(longint'(e) * k / 16);
  endfunction

  function automatic bit quiet_stretch();
    return pix_sent >= QuietFrom && pix_sent < QuietFrom + QuietLen;
  endfunction

  // dither one pixel; returns 1 when a byte goes out
  function automatic bit dither_pixel(input logic [7:0] px, output dot_byte_t res);
    int unsigned w, h, col;
    bit          row_end, last_row, white, emit;
    longint      s;
    err_t        err, b3, b5, b1, bl_next;
    w   = cfg_width;
    h   = cfg_height;
    col = col_cnt;
    if (w == 0) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    if (h == 0) h = 1;
    if (col >= MaxWidth) col = 0;
    row_end  = (col + 1) >= w;
    last_row = (row_cnt + 1) >= h;

    s     = longint'(px) * 256 + line_err[col] + right_err;
    white = s >= Threshold;
    err   = sat_err(s - (white ? WhiteLevel : 0));

    right_err = row_end ? err_t'(0) : err_share(err, 7);
    if (last_row) begin
      b3 = '0;
      b5 = '0;
      b1 = '0;
    end else begin
      b3 = err_share(err, 3);
      b5 = err_share(err, 5);
      b1 = row_end ? err_t'(0) : err_share(err, 1);
    end

    if (col > 0) line_err[col-1] = sat_err(longint'(pend_bl) + b3);
    bl_next = sat_err(longint'(pend_below) + b5);
    if (row_end) begin
      line_err[col] = bl_next;
      pend_bl       = '0;
      pend_below    = '0;
      right_err     = '0;
    end else begin
      pend_bl    = bl_next;
      pend_below = b1;
    end

    if (white) bits_acc = bits_acc | (8'h80 >> col[2:0]);
    emit = (col[2:0] == 3'd7) || row_end;
    res  = '{bits_acc, row_end, row_end && last_row};
    if (emit) bits_acc = '0;

    if (row_end) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : (row_cnt + 1) & 32'hFFFF;
    end else begin
      col_cnt = col + 1;
    end
    return emit;
  endfunction

  function automatic logic [7:0] gray_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return 8'($urandom_range(255));
    if (pick < 65) return $urandom_range(1) ? 8'hFF : 8'h00;
    if (pick < 85) return 8'($urandom_range(136, 120));
    return $urandom_range(1) ? 8'($urandom_range(255, 215)) : 8'($urandom_range(40));
  endfunction

  function automatic step_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    return '{1'b1, idx, val, 1'b0, dot_byte_t'('0)};
  endfunction

  function automatic step_t pix_row(input logic [7:0] px, input bit typed,
                                    input dot_byte_t want);
    return '{1'b0, RegImageWidth, CfgDataW'(px), typed, want};
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk_i);
    if (idx == RegImageWidth) cfg_width = val[CfgWidthW-1:0];
    else cfg_height = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic push_pixel(input logic [7:0] px, input bit typed, input dot_byte_t want);
    dot_byte_t res;
    @(negedge clk_i);
    while (!quiet_stretch() && $urandom_range(99) < IdlePct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    gray     = px;
    do @(posedge clk_i); while (in_stall);
    if (dither_pixel(px, res)) expected_bytes.push_back(typed ? want : res);
    pix_sent++;
  endtask

  // drop valid, wait out every byte, then let the last pixel finish
  task automatic settle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && pix_sent >= HoldAt) begin
        held      = 1'b1;
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_stall = !quiet_stretch() && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    dot_byte_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: packed_byte %02h row_last %0b page_last %0b",
               packed_byte, row_last, page_last);
        mismatches++;
      end else begin
        want = expected_bytes.pop_front();
        if (packed_byte !== want.pixels) begin
          $error("packed_byte: expected %02h, got %02h", want.pixels, packed_byte);
          mismatches++;
        end
        if (row_last !== want.row_end) begin
          $error("row_last: expected %0b, got %0b", want.row_end, row_last);
          mismatches++;
        end
        if (page_last !== want.page_end) begin
          $error("page_last: expected %0b, got %0b", want.page_end, page_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : sequencer
    step_t              directed [$];
    logic [CfgDataW-1:0] wval, hval;
    int unsigned        ew, eh, count, random_sent;

    cfg_width  = WidthReset;
    cfg_height = HeightReset;
    foreach (line_err[i]) line_err[i] = '0;
    right_err   = '0;
    pend_bl     = '0;
    pend_below  = '0;
    col_cnt     = 0;
    row_cnt     = 0;
    bits_acc    = '0;
    random_sent = 0;

    // single pixel pages: no carried error, so each bit is the plain threshold
    directed.push_back(cfg_row(RegImageWidth, 16'd1));
    directed.push_back(cfg_row(RegImageHeight, 16'd1));
    directed.push_back(pix_row(8'd255, 1'b1, '{8'h80, 1'b1, 1'b1}));
    directed.push_back(pix_row(8'd0,   1'b1, '{8'h00, 1'b1, 1'b1}));
    directed.push_back(pix_row(8'd128, 1'b1, '{8'h80, 1'b1, 1'b1}));
    directed.push_back(pix_row(8'd127, 1'b1, '{8'h00, 1'b1, 1'b1}));
    // zero sizes count as one
    directed.push_back(cfg_row(RegImageWidth, 16'd0));
    directed.push_back(cfg_row(RegImageHeight, 16'd0));
    directed.push_back(pix_row(8'd1,   1'b1, '{8'h00, 1'b1, 1'b1}));
    directed.push_back(pix_row(8'd254, 1'b1, '{8'h80, 1'b1, 1'b1}));
    // two short rows: diffusion below, partial bytes, page end
    directed.push_back(cfg_row(RegImageWidth, 16'd5));
    directed.push_back(cfg_row(RegImageHeight, 16'd2));
    directed.push_back(pix_row(8'd255, 1'b0, '0));
    directed.push_back(pix_row(8'd0,   1'b0, '0));
    directed.push_back(pix_row(8'd128, 1'b0, '0));
    directed.push_back(pix_row(8'd127, 1'b0, '0));
    directed.push_back(pix_row(8'd64,  1'b0, '0));
    directed.push_back(pix_row(8'd192, 1'b0, '0));
    directed.push_back(pix_row(8'd1,   1'b0, '0));
    directed.push_back(pix_row(8'd254, 1'b0, '0));
    directed.push_back(pix_row(8'd100, 1'b0, '0));
    directed.push_back(pix_row(8'd200, 1'b0, '0));
    // oversized width clamps; then shrink width and height mid-page
    directed.push_back(cfg_row(RegImageWidth, 16'hFFFF));
    directed.push_back(cfg_row(RegImageHeight, 16'hFFFF));
    directed.push_back(pix_row(8'd170, 1'b0, '0));
    directed.push_back(pix_row(8'd85,  1'b0, '0));
    directed.push_back(pix_row(8'd255, 1'b0, '0));
    directed.push_back(cfg_row(RegImageWidth, 16'd2));
    directed.push_back(pix_row(8'd30,  1'b0, '0));
    directed.push_back(cfg_row(RegImageHeight, 16'd1));
    directed.push_back(pix_row(8'd240, 1'b0, '0));
    directed.push_back(pix_row(8'd15,  1'b0, '0));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_write) begin
        settle();
        write_reg(directed[i].reg_idx, directed[i].value);
      end else begin
        push_pixel(directed[i].value[7:0], directed[i].typed, directed[i].want);
      end
    end

    // one long row; the long output hold-off lands in here
    settle();
    write_reg(RegImageWidth, CfgDataW'(LongRow));
    write_reg(RegImageHeight, 16'd1);
    repeat (LongRow) push_pixel(gray_value(), 1'b0, '0);

    while (random_sent < RandomPixels) begin
      settle();
      case ($urandom_range(9))
        0:       wval = 16'd0;
        1:       wval = CfgDataW'($urandom_range(16'hFFFF, 1025));
        2:       wval = CfgDataW'($urandom_range(64, 25));
        default: wval = CfgDataW'($urandom_range(24, 1));
      endcase
      case ($urandom_range(19))
        0, 1:    hval = 16'd0;
        2:       hval = 16'hFFFF;
        3:       hval = CfgDataW'($urandom_range(40, 7));
        default: hval = CfgDataW'($urandom_range(6, 1));
      endcase
      write_reg(RegImageWidth, wval);
      write_reg(RegImageHeight, hval);
      ew = wval[CfgWidthW-1:0];
      if (ew == 0) ew = 1;
      if (ew > MaxWidth) ew = MaxWidth;
      eh = (hval == 0) ? 1 : hval;
      // whole pages where cheap; otherwise stop mid-page
      count = (ew * eh <= 160) ? ew * eh : $urandom_range(120, 10);
      repeat (count) push_pixel(gray_value(), 1'b0, '0);
      random_sent += count;
    end

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fsd_pkg.sv
rtl/fsd_ram.sv
rtl/fsd_err_unit.sv
rtl/floyd_steinberg_1bpp_packer_core.sv
tb/sv/floyd_steinberg_1bpp_packer_core_tb.sv
